// ===== hdl/ipv4_prefix_ban_filter_macros.svh =====
// Assertion macros shared by the filter RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef IPV4_PREFIX_BAN_FILTER_MACROS_SVH
`define IPV4_PREFIX_BAN_FILTER_MACROS_SVH

`define IPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define IPB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ipb_pkg.sv =====
// Package for the IPv4 prefix ban filter: sizes, codes, types and helpers.
// No dependencies.
`timescale 1ns / 1ps

package ipb_pkg;

  localparam int GLOBAL_SLOTS   = 64;
  localparam int HOST_SLOTS     = 64;
  localparam int DIRECTED_SLOTS = 128;
  localparam int NUM_STATS      = 4;

  localparam int MAX_SLOTS_GH = (GLOBAL_SLOTS > HOST_SLOTS) ? GLOBAL_SLOTS : HOST_SLOTS;
  localparam int MAX_SLOTS = (MAX_SLOTS_GH > DIRECTED_SLOTS) ? MAX_SLOTS_GH : DIRECTED_SLOTS;
  localparam int SLOT_W = $clog2((MAX_SLOTS > 1) ? MAX_SLOTS : 2);

  localparam logic [2:0] MODE_PACKET      = 3'd0;
  localparam logic [2:0] MODE_WR_GLOBAL   = 3'd1;
  localparam logic [2:0] MODE_WR_HOST     = 3'd2;
  localparam logic [2:0] MODE_WR_DIRECTED = 3'd3;
  localparam logic [2:0] MODE_RD_STAT     = 3'd4;

  localparam logic [1:0] STAT_DROPPED    = 2'd0;
  localparam logic [1:0] STAT_PASSED     = 2'd1;
  localparam logic [1:0] STAT_EXPIRED    = 2'd2;
  localparam logic [1:0] STAT_NOT_TARGET = 2'd3;

  localparam logic [5:0]  MAX_PLEN  = 6'd32;
  localparam logic [15:0] IPV4_TYPE = 16'h0800;

  typedef enum logic [2:0] {
    RSN_NOT_IPV4,
    RSN_GLB_DROP,
    RSN_GLB_EXPIRED,
    RSN_NOT_TARGET,
    RSN_NO_DIRECTED,
    RSN_DIR_EXPIRED,
    RSN_DIR_DROP,
    RSN_DONE
  } reason_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GLB,
    ST_GLB_END,
    ST_HOST,
    ST_HOST_END,
    ST_DIR,
    ST_DIR_END,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [15:0] tid;
    logic [5:0]  len;
    logic [31:0] addr;
    logic [63:0] expiry;
    logic [31:0] rule;
    logic [63:0] hits;
  } body_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        frame_ok;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [63:0] now_ns;
    logic [7:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  prefix_len;
    logic [15:0] host_tag;
    logic [63:0] expiry_ns;
    logic [31:0] rule_number;
  } req_t;

  typedef struct packed {
    logic        verdict;
    reason_e     reason;
    logic [31:0] rule;
    logic [63:0] count;
  } res_t;

  function automatic logic [63:0] sat_inc(input logic [63:0] v);
    return (v == '1) ? v : v + 64'd1;
  endfunction

  function automatic logic prefix_hit(input logic [31:0] a, input logic [31:0] p,
                                      input logic [5:0] len);
    logic [31:0] mask;
    mask = (len >= MAX_PLEN) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> len);
    return ((a ^ p) & mask) == 32'd0;
  endfunction

endpackage

// ===== hdl/ipb_if.sv =====
// Valid/ready channel interfaces for the filter's request and result streams.
// Depends on ipb_pkg.
`timescale 1ns / 1ps

interface ipb_in_if import ipb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        frame_ok;
  logic [15:0] ether_type;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [63:0] now_ns;
  logic [7:0]  entry_index;
  logic        entry_valid;
  logic [5:0]  prefix_len;
  logic [15:0] host_tag;
  logic [63:0] expiry_ns;
  logic [31:0] rule_number;

  modport source (output valid, mode, frame_ok, ether_type, src_addr, dst_addr, now_ns,
                  entry_index, entry_valid, prefix_len, host_tag, expiry_ns,
                  rule_number, input ready);
  modport sink (input valid, mode, frame_ok, ether_type, src_addr, dst_addr, now_ns,
                entry_index, entry_valid, prefix_len, host_tag, expiry_ns,
                rule_number, output ready);
endinterface

interface ipb_out_if import ipb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [2:0]  reason;
  logic [31:0] matched_rule;
  logic [63:0] count;

  modport source (output valid, verdict, reason, matched_rule, count, input ready);
  modport sink (input valid, verdict, reason, matched_rule, count, output ready);
endinterface

// ===== hdl/ipb_cell.sv =====
// One table slot of a rotating rule ring: holds an entry and passes it to its neighbor.
// Depends on ipb_pkg.
`timescale 1ns / 1ps

module ipb_cell import ipb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  shift_valid_i,
  input  body_t shift_body_i,
  input  logic  wr_i,
  input  logic  wr_valid_i,
  input  body_t wr_body_i,
  input  logic  inc_i,
  output logic  valid_o,
  output body_t body_o
);

  logic  valid_q;
  body_t body_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= wr_valid_i;
    end else if (shift_i) begin
      valid_q <= shift_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      body_q <= wr_body_i;
    end else if (shift_i) begin
      body_q <= shift_body_i;
    end else if (inc_i) begin
      body_q.hits <= sat_inc(body_q.hits);
    end
  end

  assign valid_o = valid_q;
  assign body_o  = body_q;

endmodule

// ===== hdl/ipv4_prefix_ban_filter.sv =====
// Top level of the IPv4 prefix ban filter: control sequencer and three rule rings.
// Depends on ipb_pkg, ipb_if, ipb_cell and ipv4_prefix_ban_filter_macros.svh.
//
// Requests arrive on in_if and results leave on out_if, one result per request;
// a transfer happens on a clock edge where valid and ready are both high.
// Mode 0 judges a packet; modes 1 to 3 write a global rule, a protected host or a
// directed rule; mode 4 reads a statistics counter; other modes just answer.
// Each table is a ring of cells that rotates once past a single compare head,
// one slot per cycle, and is back home when the scan ends.
// A write, a read or a non-IPv4 frame skips the rings and goes straight to the closing state.
// An IPv4 packet walks the global ring, the host ring and the directed ring with a
// closing state after each; a global hit skips the later rings, and a packet whose
// destination is no protected host skips the directed ring.
// One request is in flight at a time; in_if.ready is high only while idle.
// The result sits in an output register; while the receiver stalls, the block
// finishes the next request's scan but holds it until the register frees up.
// Reset clears all valid bits, the statistics and the sequencer; no clearing
// pass is needed.
`timescale 1ns / 1ps
`include "ipv4_prefix_ban_filter_macros.svh"

module ipv4_prefix_ban_filter import ipb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipb_in_if.sink    in_if,
  ipb_out_if.source out_if
);

  state_e state_q, state_d;
  req_t   req_q, in_req;
  res_t   res_q, out_q;
  logic   out_valid_q;

  logic [SLOT_W-1:0] cnt_q, bslot_q;
  logic              bfound_q, hfound_q;
  logic [5:0]        blen_q;
  logic [63:0]       bexp_q, bhits_q;
  logic [31:0]       brule_q;
  logic [15:0]       tid_q;
  logic              inc_glb_q, inc_dir_q, stat_inc_q;
  logic [1:0]        stat_idx_q;
  logic [63:0]       stats_q [NUM_STATS];

  logic  in_fire, fin_fire, g_shift, h_shift, d_shift, stale;
  logic  g_better, h_hit, d_better, is_ipv4;
  logic [5:0] wr_len;
  body_t wr_body;

  logic  g_valid [GLOBAL_SLOTS];
  body_t g_body  [GLOBAL_SLOTS];
  logic  h_valid [HOST_SLOTS];
  body_t h_body  [HOST_SLOTS];
  logic  d_valid [DIRECTED_SLOTS];
  body_t d_body  [DIRECTED_SLOTS];

  assign in_req = '{mode: in_if.mode, frame_ok: in_if.frame_ok, ether_type: in_if.ether_type,
                    src_addr: in_if.src_addr, dst_addr: in_if.dst_addr, now_ns: in_if.now_ns,
                    entry_index: in_if.entry_index, entry_valid: in_if.entry_valid,
                    prefix_len: in_if.prefix_len, host_tag: in_if.host_tag,
                    expiry_ns: in_if.expiry_ns, rule_number: in_if.rule_number};

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && (state_q == ST_IDLE);
  assign is_ipv4     = in_if.frame_ok && (in_if.ether_type == IPV4_TYPE);

  assign wr_len = (req_q.prefix_len > MAX_PLEN) ? MAX_PLEN : req_q.prefix_len;
  always_comb begin
    wr_body.tid    = req_q.host_tag;
    wr_body.len    = wr_len;
    wr_body.addr   = (req_q.mode == MODE_WR_HOST) ? req_q.dst_addr : req_q.src_addr;
    wr_body.expiry = req_q.expiry_ns;
    wr_body.rule   = req_q.rule_number;
    wr_body.hits   = 64'd0;
  end

  // Compare head: slot cnt_q of the rotating table sits in cell 0.
  assign g_better = g_valid[0] && prefix_hit(req_q.src_addr, g_body[0].addr, g_body[0].len)
                    && (!bfound_q || (g_body[0].len > blen_q));
  assign h_hit    = h_valid[0] && (h_body[0].addr == req_q.dst_addr);
  assign d_better = d_valid[0] && (d_body[0].tid == tid_q)
                    && prefix_hit(req_q.src_addr, d_body[0].addr, d_body[0].len)
                    && (!bfound_q || (d_body[0].len > blen_q));
  assign stale    = (bexp_q != 64'd0) && (req_q.now_ns > bexp_q);

  for (genvar i = 0; i < GLOBAL_SLOTS; i++) begin : g_ring
    ipb_cell u_cell (
      .clk_i, .rst_ni,
      .shift_i      (g_shift),
      .shift_valid_i(g_valid[(i + 1) % GLOBAL_SLOTS]),
      .shift_body_i (g_body[(i + 1) % GLOBAL_SLOTS]),
      .wr_i         (fin_fire && (req_q.mode == MODE_WR_GLOBAL)
                     && (32'(req_q.entry_index) == 32'(i))),
      .wr_valid_i   (req_q.entry_valid),
      .wr_body_i    (wr_body),
      .inc_i        (fin_fire && inc_glb_q && (bslot_q == SLOT_W'(i))),
      .valid_o      (g_valid[i]),
      .body_o       (g_body[i])
    );
  end

  for (genvar i = 0; i < HOST_SLOTS; i++) begin : h_ring
    ipb_cell u_cell (
      .clk_i, .rst_ni,
      .shift_i      (h_shift),
      .shift_valid_i(h_valid[(i + 1) % HOST_SLOTS]),
      .shift_body_i (h_body[(i + 1) % HOST_SLOTS]),
      .wr_i         (fin_fire && (req_q.mode == MODE_WR_HOST)
                     && (32'(req_q.entry_index) == 32'(i))),
      .wr_valid_i   (req_q.entry_valid),
      .wr_body_i    (wr_body),
      .inc_i        (1'b0),
      .valid_o      (h_valid[i]),
      .body_o       (h_body[i])
    );
  end

  for (genvar i = 0; i < DIRECTED_SLOTS; i++) begin : d_ring
    ipb_cell u_cell (
      .clk_i, .rst_ni,
      .shift_i      (d_shift),
      .shift_valid_i(d_valid[(i + 1) % DIRECTED_SLOTS]),
      .shift_body_i (d_body[(i + 1) % DIRECTED_SLOTS]),
      .wr_i         (fin_fire && (req_q.mode == MODE_WR_DIRECTED)
                     && (32'(req_q.entry_index) == 32'(i))),
      .wr_valid_i   (req_q.entry_valid),
      .wr_body_i    (wr_body),
      .inc_i        (fin_fire && inc_dir_q && (bslot_q == SLOT_W'(i))),
      .valid_o      (d_valid[i]),
      .body_o       (d_body[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    g_shift  = 1'b0;
    h_shift  = 1'b0;
    d_shift  = 1'b0;
    fin_fire = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ((in_if.mode == MODE_PACKET) && is_ipv4) ? ST_GLB : ST_FIN;
        end
      end
      ST_GLB: begin
        g_shift = 1'b1;
        if (cnt_q == SLOT_W'(GLOBAL_SLOTS - 1)) begin
          state_d = ST_GLB_END;
        end
      end
      ST_GLB_END: state_d = bfound_q ? ST_FIN : ST_HOST;
      ST_HOST: begin
        h_shift = 1'b1;
        if (cnt_q == SLOT_W'(HOST_SLOTS - 1)) begin
          state_d = ST_HOST_END;
        end
      end
      ST_HOST_END: state_d = hfound_q ? ST_DIR : ST_FIN;
      ST_DIR: begin
        d_shift = 1'b1;
        if (cnt_q == SLOT_W'(DIRECTED_SLOTS - 1)) begin
          state_d = ST_DIR_END;
        end
      end
      ST_DIR_END: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          fin_fire = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers of the scan and the side effects applied at completion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bfound_q    <= 1'b0;
      hfound_q    <= 1'b0;
      inc_glb_q   <= 1'b0;
      inc_dir_q   <= 1'b0;
      stat_inc_q  <= 1'b0;
      stat_idx_q  <= STAT_DROPPED;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_STATS; k++) begin
        stats_q[k] <= 64'd0;
      end
    end else begin
      if (in_fire) begin
        cnt_q      <= '0;
        bfound_q   <= 1'b0;
        hfound_q   <= 1'b0;
        inc_glb_q  <= 1'b0;
        inc_dir_q  <= 1'b0;
        stat_inc_q <= 1'b0;
      end
      if (g_shift || h_shift || d_shift) begin
        cnt_q <= (state_d != state_q) ? '0 : cnt_q + SLOT_W'(1);
      end
      if ((g_shift && g_better) || (d_shift && d_better)) begin
        bfound_q <= 1'b1;
      end
      if (h_shift && h_hit) begin
        hfound_q <= 1'b1;
      end
      if (state_q == ST_GLB_END) begin
        bfound_q <= 1'b0;
        if (bfound_q) begin
          stat_inc_q <= 1'b1;
          stat_idx_q <= stale ? STAT_EXPIRED : STAT_DROPPED;
          inc_glb_q  <= !stale;
        end
      end
      if ((state_q == ST_HOST_END) && !hfound_q) begin
        stat_inc_q <= 1'b1;
        stat_idx_q <= STAT_NOT_TARGET;
      end
      if (state_q == ST_DIR_END) begin
        stat_inc_q <= 1'b1;
        if (!bfound_q) begin
          stat_idx_q <= STAT_PASSED;
        end else begin
          stat_idx_q <= stale ? STAT_EXPIRED : STAT_DROPPED;
          inc_dir_q  <= !stale;
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
        inc_glb_q   <= 1'b0;
        inc_dir_q   <= 1'b0;
        stat_inc_q  <= 1'b0;
        if (stat_inc_q) begin
          stats_q[stat_idx_q] <= sat_inc(stats_q[stat_idx_q]);
        end
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q         <= in_req;
      res_q.verdict <= 1'b0;
      res_q.reason  <= (in_if.mode == MODE_PACKET) ? RSN_NOT_IPV4 : RSN_DONE;
      res_q.rule    <= 32'd0;
      res_q.count   <= ((in_if.mode == MODE_RD_STAT) && (in_if.entry_index < 8'(NUM_STATS)))
                       ? stats_q[in_if.entry_index[1:0]] : 64'd0;
    end
    if ((g_shift && g_better) || (d_shift && d_better)) begin
      bslot_q <= cnt_q;
      blen_q  <= g_shift ? g_body[0].len : d_body[0].len;
      bexp_q  <= g_shift ? g_body[0].expiry : d_body[0].expiry;
      brule_q <= g_shift ? g_body[0].rule : d_body[0].rule;
      bhits_q <= g_shift ? g_body[0].hits : d_body[0].hits;
    end
    if (h_shift && h_hit && !hfound_q) begin
      tid_q <= h_body[0].tid;
    end
    if ((state_q == ST_GLB_END) && bfound_q) begin
      res_q.verdict <= !stale;
      res_q.reason  <= stale ? RSN_GLB_EXPIRED : RSN_GLB_DROP;
      res_q.rule    <= brule_q;
      res_q.count   <= stale ? 64'd0 : sat_inc(bhits_q);
    end
    if ((state_q == ST_HOST_END) && !hfound_q) begin
      res_q.verdict <= 1'b0;
      res_q.reason  <= RSN_NOT_TARGET;
      res_q.rule    <= 32'd0;
      res_q.count   <= 64'd0;
    end
    if (state_q == ST_DIR_END) begin
      if (!bfound_q) begin
        res_q.verdict <= 1'b0;
        res_q.reason  <= RSN_NO_DIRECTED;
        res_q.rule    <= 32'd0;
        res_q.count   <= 64'd0;
      end else begin
        res_q.verdict <= !stale;
        res_q.reason  <= stale ? RSN_DIR_EXPIRED : RSN_DIR_DROP;
        res_q.rule    <= brule_q;
        res_q.count   <= stale ? 64'd0 : sat_inc(bhits_q);
      end
    end
    if (fin_fire) begin
      out_q <= res_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.verdict      = out_q.verdict;
  assign out_if.reason       = out_q.reason;
  assign out_if.matched_rule = out_q.rule;
  assign out_if.count        = out_q.count;

  `IPB_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q), "not idle after reset")
  `IPB_ASSERT(a_drop_reason, out_valid_q |-> (out_q.verdict == (out_q.reason == RSN_GLB_DROP || out_q.reason == RSN_DIR_DROP)), "verdict disagrees with reason")
  `IPB_ASSERT(a_drop_count, (out_valid_q && out_q.verdict) |-> (out_q.count != 64'd0), "drop with zero hit count")
  `IPB_ASSERT(a_accept_busy, in_fire |=> (state_q != ST_IDLE), "request transfer did not start work")

endmodule
